/* sv/fsmatch_pkg.sv */
package fsmatch_pkg;

  localparam int MAX_PATTERN_DEFAULT = 32;
  localparam int COLUMN_BITS_DEFAULT = 16;
  localparam int LINE_BITS_DEFAULT   = 20;

  localparam int PATTERN_WORDS  = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MATCH_CASE     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WHOLE_WORDS    = 3'd6;

  typedef struct packed {
    logic [PATTERN_WORDS-1:0][CFG_DATA_BITS-1:0] pattern_word;
    logic [5:0]                                  pattern_length;
    logic                                        match_case;
    logic                                        whole_words;
  } cfg_t;

  // fold targets for Latin-1 0xC0..0xFF, zero means the byte is unchanged
  localparam logic [7:0] FOLD_HIGH [64] = '{
    8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h00, 8'h63,
    8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
    8'h00, 8'h6E, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h00,
    8'h6F, 8'h75, 8'h75, 8'h75, 8'h75, 8'h00, 8'h00, 8'h00,
    8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h00, 8'h63,
    8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h69, 8'h69,
    8'h00, 8'h6E, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h00,
    8'h6F, 8'h75, 8'h75, 8'h75, 8'h75, 8'h79, 8'h00, 8'h79
  };

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] t;
    t = FOLD_HIGH[b[5:0]];
    if (b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    if (b >= 8'hC0 && t != 8'h00) return t;
    return b;
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return 1'b1;
    if (b >= 8'h41 && b <= 8'h5A) return 1'b1;
    if (b >= 8'h61 && b <= 8'h7A) return 1'b1;
    if (b == 8'h5F) return 1'b1;
    return b >= 8'hC0 && b != 8'hD7 && b != 8'hF7;
  endfunction

endpackage

/* sv/fsmatch_window.sv */
module fsmatch_window #(
  parameter int MAX_PATTERN = fsmatch_pkg::MAX_PATTERN_DEFAULT,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  fsmatch_pkg::cfg_t cfg,
  input  logic [7:0]        win_raw  [MAX_PATTERN],
  input  logic [7:0]        win_fold [MAX_PATTERN],
  output logic [LEN_W-1:0]  eff_len,
  output logic              window_hit
);
  import fsmatch_pkg::*;

  logic [7:0]             pat [MAX_PATTERN];
  logic [7:0]             aligned [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit_bits;

  always_comb begin
    if (cfg.pattern_length == 6'd0) begin
      eff_len = LEN_W'(1);
    end else if ({1'b0, cfg.pattern_length} > 7'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(cfg.pattern_length);
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < PATTERN_WORDS * 8) begin : g_real
      assign pat[k] = cfg.pattern_word[k / 8][(k % 8) * 8 +: 8];
    end else begin : g_zero
      assign pat[k] = 8'h00;
    end
  end

  // window slot i (0 = newest byte) lines up with pattern byte len-1-i
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_slot
    always_comb begin
      aligned[i] = 8'h00;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (k + i + 1 == int'(eff_len)) aligned[i] = pat[k];
      end
    end

    always_comb begin
      if (i >= int'(eff_len)) begin
        hit_bits[i] = 1'b1;
      end else if (cfg.match_case) begin
        hit_bits[i] = (aligned[i] == win_raw[i]);
      end else begin
        hit_bits[i] = (fold_byte(aligned[i]) == win_fold[i]);
      end
    end
  end

  assign window_hit = &hit_bits;

endmodule

/* sv/fsmatch_skid.sv */
module fsmatch_skid #(
  parameter int WIDTH = fsmatch_pkg::LINE_BITS_DEFAULT + fsmatch_pkg::COLUMN_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_data
);
  import fsmatch_pkg::*;

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             out_take;

  assign out_take = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_data <= skid_data;
    end else if (push) begin
      if (!out_valid || out_take) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

/* sv/folded_substring_matcher_unit.sv */
// Case-folding substring search over a byte stream.
// Input channel (in_valid/in_stall): one request per text byte, or a line_end
// request that closes the current line. Output channel (out_valid/out_stall):
// one request per reported match start, giving match_line and match_column.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; the
// user must write it only while the stream is idle (the block does not enforce
// this): pattern words, length, match_case, whole_words.
// Throughput is one input request per cycle while in_stall is low. A match is
// registered in the output stages as the byte completing it is accepted; with
// whole_words set this waits for the next byte or line end to be accepted.
// The window compare against all pattern bytes is done in the accept cycle.
// Results pass an output register and a one-entry skid stage, so input keeps
// flowing for one result while the receiver stalls; in_stall rises only when
// the skid stage holds a result.
// Reset (rst, synchronous) clears counters, pending state, the output stages
// and the registers (pattern_length back to 1).
module folded_substring_matcher_unit #(
  parameter int MAX_PATTERN = fsmatch_pkg::MAX_PATTERN_DEFAULT,
  parameter int COLUMN_BITS = fsmatch_pkg::COLUMN_BITS_DEFAULT,
  parameter int LINE_BITS   = fsmatch_pkg::LINE_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             text_byte,
  input  logic                                   line_end,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [LINE_BITS-1:0]                   match_line,
  output logic [COLUMN_BITS-1:0]                 match_column,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fsmatch_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fsmatch_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import fsmatch_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  cfg_t                   cfg;
  logic [7:0]             recent      [MAX_PATTERN];
  logic [7:0]             recent_fold [MAX_PATTERN];
  logic [7:0]             win_raw     [MAX_PATTERN];
  logic [7:0]             win_fold    [MAX_PATTERN];
  logic [COLUMN_BITS-1:0] column_count;
  logic [LINE_BITS-1:0]   line_count;
  logic                   pending_match;
  logic [COLUMN_BITS-1:0] pending_column;

  logic                   accept;
  logic [LEN_W-1:0]       eff_len;
  logic                   window_hit;
  logic [7:0]             text_fold;
  logic [7:0]             left_byte;
  logic [COLUMN_BITS-1:0] column_next;
  logic [COLUMN_BITS-1:0] start_column;
  logic                   found;
  logic                   pending_hit;
  logic                   pending_match_next;
  logic [COLUMN_BITS-1:0] pending_column_next;
  logic                   res_valid;
  logic [COLUMN_BITS-1:0] res_column;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign text_fold = fold_byte(text_byte);

  // window as it stands once the incoming byte is shifted in
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
    if (i == 0) begin : g_head
      assign win_raw[i]  = text_byte;
      assign win_fold[i] = text_fold;
    end else begin : g_tail
      assign win_raw[i]  = recent[i-1];
      assign win_fold[i] = recent_fold[i-1];
    end
  end

  fsmatch_window #(
    .MAX_PATTERN(MAX_PATTERN),
    .LEN_W      (LEN_W)
  ) u_window (
    .cfg       (cfg),
    .win_raw   (win_raw),
    .win_fold  (win_fold),
    .eff_len   (eff_len),
    .window_hit(window_hit)
  );

  // byte just before the match start
  always_comb begin
    left_byte = 8'h00;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (j + 1 == int'(eff_len)) left_byte = recent[j];
    end
  end

  assign column_next  = (column_count == '1) ? column_count : column_count + 1'b1;
  assign start_column = column_next - COLUMN_BITS'(eff_len);
  assign found        = window_hit && (column_next >= COLUMN_BITS'(eff_len));

  always_comb begin
    res_valid           = 1'b0;
    res_column          = pending_column;
    pending_hit         = 1'b0;
    pending_match_next  = 1'b0;
    pending_column_next = pending_column;
    if (line_end) begin
      res_valid = pending_match;
    end else begin
      pending_hit = pending_match && !is_word(text_byte);
      res_valid   = pending_hit;
      if (found) begin
        if (!cfg.whole_words) begin
          // a pending report takes precedence over a new one
          if (!pending_hit) begin
            res_valid  = 1'b1;
            res_column = start_column;
          end
        end else if (start_column == '0 || !is_word(left_byte)) begin
          pending_match_next  = 1'b1;
          pending_column_next = start_column;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_word   <= '0;
      cfg.pattern_length <= 6'd1;
      cfg.match_case     <= 1'b0;
      cfg.whole_words    <= 1'b0;
      column_count       <= '0;
      line_count         <= '0;
      pending_match      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PATTERN_WORD_0: cfg.pattern_word[0] <= cfg_data;
          CFG_PATTERN_WORD_1: cfg.pattern_word[1] <= cfg_data;
          CFG_PATTERN_WORD_2: cfg.pattern_word[2] <= cfg_data;
          CFG_PATTERN_WORD_3: cfg.pattern_word[3] <= cfg_data;
          CFG_PATTERN_LENGTH: cfg.pattern_length  <= cfg_data[5:0];
          CFG_MATCH_CASE:     cfg.match_case      <= cfg_data[0];
          CFG_WHOLE_WORDS:    cfg.whole_words     <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        pending_match <= pending_match_next;
        if (line_end) begin
          if (line_count != '1) line_count <= line_count + 1'b1;
          column_count <= '0;
        end else begin
          column_count <= column_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_column <= pending_column_next;
      if (!line_end) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          recent[i]      <= win_raw[i];
          recent_fold[i] <= win_fold[i];
        end
      end
    end
  end

  fsmatch_skid #(
    .WIDTH(LINE_BITS + COLUMN_BITS)
  ) u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && res_valid),
    .push_data({line_count, res_column}),
    .full     (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data ({match_line, match_column})
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import fsmatch_pkg::*;

  localparam int unsigned COL_CEIL  = (1 << COLUMN_BITS_DEFAULT) - 1;
  localparam int unsigned LINE_CEIL = (1 << LINE_BITS_DEFAULT) - 1;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [LINE_BITS_DEFAULT-1:0]   line;
    logic [COLUMN_BITS_DEFAULT-1:0] col;
  } match_pos_t;

  typedef enum logic [1:0] {ROW_TEXT, ROW_EOL, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HIT} row_chk_e;

  typedef struct {
    row_kind_e                      kind;
    logic [CFG_DATA_BITS-1:0]       data;
    logic [CFG_INDEX_BITS-1:0]      idx;
    row_chk_e                       chk;
    logic [LINE_BITS_DEFAULT-1:0]   line;
    logic [COLUMN_BITS_DEFAULT-1:0] col;
  } row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [7:0]                        text_byte = 8'h00;
  logic                              line_end = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [LINE_BITS_DEFAULT-1:0]      match_line;
  logic [COLUMN_BITS_DEFAULT-1:0]    match_column;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [CFG_INDEX_BITS-1:0]         cfg_index = CFG_PATTERN_WORD_0;
  logic [CFG_DATA_BITS-1:0]          cfg_data = '0;

  folded_substring_matcher_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .line_end     (line_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .match_line   (match_line),
    .match_column (match_column),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // matcher shadow: registers and scan state
  logic [CFG_DATA_BITS-1:0] pat_word [PATTERN_WORDS];
  logic [5:0]               pat_len = 6'd1;
  bit                       exact_case = 1'b0;
  bit                       word_bound = 1'b0;
  logic [7:0]               history [0:32];
  int unsigned              col_cnt = 0;
  int unsigned              line_cnt = 0;
  bit                       held_match = 1'b0;
  int unsigned              held_col = 0;

  match_pos_t expected_matches [$];
  row_t       script [$];

  int errors = 0;
  int requests_sent = 0;
  int matches_seen = 0;
  int settings_applied = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen;
  int unsigned hold_left;

  initial begin
    foreach (pat_word[i]) pat_word[i] = '0;
    foreach (history[i]) history[i] = 8'h00;
  end

  function automatic logic [7:0] base_letter(input logic [7:0] b);
    logic [4:0] lo;
    lo = b[4:0];
    if (b >= "A" && b <= "Z") return b + 8'd32;
    if (b < 8'hC0) return b;
    if (lo <= 5'd5) return "a";
    if (lo == 5'd7) return "c";
    if (lo >= 5'd8 && lo <= 5'd11) return "e";
    if (lo >= 5'd12 && lo <= 5'd15) return "i";
    if (lo == 5'd17) return "n";
    if ((lo >= 5'd18 && lo <= 5'd22) || lo == 5'd24) return "o";
    if (lo >= 5'd25 && lo <= 5'd28) return "u";
    // only the lower-case forms of y-acute and y-diaeresis fold
    if ((lo == 5'd29 || lo == 5'd31) && b[5]) return "y";
    return b;
  endfunction

  function automatic bit word_char(input logic [7:0] b);
    if (b >= "0" && b <= "9") return 1'b1;
    if (b >= "A" && b <= "Z") return 1'b1;
    if (b >= "a" && b <= "z") return 1'b1;
    if (b == "_") return 1'b1;
    return b >= 8'hC0 && b != 8'hD7 && b != 8'hF7;
  endfunction

  function automatic logic [7:0] pattern_at(input int unsigned k);
    return pat_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic int unsigned used_length();
    if (pat_len == 6'd0) return 1;
    if (pat_len > 6'd32) return 32;
    return pat_len;
  endfunction

  function automatic bit window_hit(input int unsigned n);
    logic [7:0] p;
    logic [7:0] t;
    for (int unsigned k = 0; k < n; k++) begin
      p = pattern_at(k);
      t = history[n - 1 - k];
      if (exact_case) begin
        if (p != t) return 1'b0;
      end else if (base_letter(p) != base_letter(t)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void scan_request(input logic [7:0] b, input logic le, output bit found,
                                       output match_pos_t pos);
    int unsigned n;
    int unsigned start;
    found = 1'b0;
    pos = '0;
    if (le) begin
      if (held_match) begin
        found = 1'b1;
        pos.line = LINE_BITS_DEFAULT'(line_cnt);
        pos.col = COLUMN_BITS_DEFAULT'(held_col);
      end
      held_match = 1'b0;
      if (line_cnt < LINE_CEIL) line_cnt++;
      col_cnt = 0;
      return;
    end
    if (held_match) begin
      if (!word_char(b)) begin
        found = 1'b1;
        pos.line = LINE_BITS_DEFAULT'(line_cnt);
        pos.col = COLUMN_BITS_DEFAULT'(held_col);
      end
      held_match = 1'b0;
    end
    for (int k = 32; k > 0; k--) history[k] = history[k - 1];
    history[0] = b;
    if (col_cnt < COL_CEIL) col_cnt++;
    n = used_length();
    if (col_cnt >= n && window_hit(n)) begin
      start = col_cnt - n;
      if (!word_bound) begin
        // a second report in the same request is dropped
        if (!found) begin
          found = 1'b1;
          pos.line = LINE_BITS_DEFAULT'(line_cnt);
          pos.col = COLUMN_BITS_DEFAULT'(start);
        end
      end else if (start == 0 || !word_char(history[n])) begin
        held_match = 1'b1;
        held_col = start;
      end
    end
  endfunction

  task automatic send_request(input logic [7:0] b, input logic le, input row_chk_e chk,
                              input match_pos_t typed);
    bit found;
    match_pos_t pos;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    line_end  <= le;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    scan_request(b, le, found, pos);
    if (chk == CHK_HIT) expected_matches.push_back(typed);
    else if (chk == CHK_MODEL && found) expected_matches.push_back(pos);
  endtask

  task automatic send_text(input logic [7:0] b);
    send_request(b, 1'b0, CHK_MODEL, '0);
  endtask

  task automatic send_eol();
    send_request(8'h00, 1'b1, CHK_MODEL, '0);
  endtask

  // stop offering, then let every outstanding match drain
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PATTERN_WORD_0: pat_word[0] = value;
      CFG_PATTERN_WORD_1: pat_word[1] = value;
      CFG_PATTERN_WORD_2: pat_word[2] = value;
      CFG_PATTERN_WORD_3: pat_word[3] = value;
      CFG_PATTERN_LENGTH: pat_len = value[5:0];
      CFG_MATCH_CASE:     exact_case = value[0];
      CFG_WHOLE_WORDS:    word_bound = value[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [7:0] pbytes [32], input logic [5:0] len,
                               input bit mc, input bit ww);
    logic [CFG_DATA_BITS-1:0] w;
    settle();
    for (int i = 0; i < PATTERN_WORDS; i++) begin
      for (int j = 0; j < 8; j++) w[j * 8 +: 8] = pbytes[i * 8 + j];
      write_reg(CFG_PATTERN_WORD_0 + i[CFG_INDEX_BITS-1:0], w);
    end
    write_reg(CFG_PATTERN_LENGTH, {58'd0, len});
    write_reg(CFG_MATCH_CASE, {63'd0, mc});
    write_reg(CFG_WHOLE_WORDS, {63'd0, ww});
    settings_applied++;
  endtask

  function automatic void add_row(input row_kind_e kind, input logic [CFG_DATA_BITS-1:0] data,
                                  input logic [CFG_INDEX_BITS-1:0] idx, input row_chk_e chk,
                                  input int unsigned line, input int unsigned col);
    row_t r;
    r.kind = kind;
    r.data = data;
    r.idx = idx;
    r.chk = chk;
    r.line = LINE_BITS_DEFAULT'(line);
    r.col = COLUMN_BITS_DEFAULT'(col);
    script.push_back(r);
  endfunction

  // mostly a small alphabet so partial and overlapping matches are common
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] alphabet [14];
    alphabet = '{"a", "A", 8'hE1, 8'hC0, "b", "B", "_", " ", ".", 8'hD7, "1", 8'hFF,
                 8'hFD, "y"};
    if ($urandom_range(5) == 0) return 8'($urandom_range(255));
    return alphabet[$urandom_range(13)];
  endfunction

  function automatic logic [7:0] pick_boundary();
    case ($urandom_range(4))
      0: return " ";
      1: return ".";
      2: return 8'hD7;
      3: return 8'hF7;
      default: return pick_text_byte();
    endcase
  endfunction

  // any byte that compares equal to p under the current case rule
  function automatic logic [7:0] pick_variant(input logic [7:0] p);
    int cnt;
    int sel;
    cnt = 0;
    if (exact_case) return p;
    for (int v = 0; v < 256; v++) if (base_letter(8'(v)) == base_letter(p)) cnt++;
    sel = $urandom_range(cnt - 1);
    for (int v = 0; v < 256; v++) begin
      if (base_letter(8'(v)) == base_letter(p)) begin
        if (sel == 0) return 8'(v);
        sel--;
      end
    end
    return p;
  endfunction

  task automatic send_burst();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 55) begin
      if ($urandom_range(1)) send_text(pick_boundary());
      n = used_length();
      for (int k = 0; k < n; k++) send_text(pick_variant(pattern_at(k)));
      case ($urandom_range(3))
        0: send_eol();
        1: send_text(pick_boundary());
        2: send_text("a");
        default: ;
      endcase
    end else if (r < 88) begin
      n = $urandom_range(1, 8);
      repeat (n) send_text(pick_text_byte());
    end else begin
      send_eol();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_matches
    match_pos_t want;
    if (!rst && out_valid && !out_stall) begin
      matches_seen++;
      if (expected_matches.size() == 0) begin
        $error("unexpected match: line %0d column %0d", match_line, match_column);
        errors++;
      end else begin
        want = expected_matches.pop_front();
        if (match_line !== want.line) begin
          $error("match_line: expected %0d, got %0d", want.line, match_line);
          errors++;
        end
        if (match_column !== want.col) begin
          $error("match_column: expected %0d, got %0d", want.col, match_column);
          errors++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [7:0] pbytes [32];
    logic [5:0] len;
    bit         mc;
    bit         ww;
    bit         prev_reg;
    int         start_count;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: single zero byte, folded compare
    add_row(ROW_TEXT, 8'h00, '0, CHK_HIT, 0, 0);
    add_row(ROW_TEXT, 8'hFF, '0, CHK_NONE, 0, 0);
    add_row(ROW_TEXT, 8'h00, '0, CHK_HIT, 0, 2);
    add_row(ROW_EOL, 8'h00, '0, CHK_NONE, 0, 0);
    add_row(ROW_TEXT, 8'h00, '0, CHK_HIT, 1, 0);
    // "CaF" + E-acute, folded, whole words
    add_row(ROW_REG, 64'h0000_0000_C946_6143, CFG_PATTERN_WORD_0, CHK_NONE, 0, 0);
    add_row(ROW_REG, '0, CFG_PATTERN_WORD_1, CHK_NONE, 0, 0);
    add_row(ROW_REG, '0, CFG_PATTERN_WORD_2, CHK_NONE, 0, 0);
    add_row(ROW_REG, '0, CFG_PATTERN_WORD_3, CHK_NONE, 0, 0);
    add_row(ROW_REG, 64'd4, CFG_PATTERN_LENGTH, CHK_NONE, 0, 0);
    add_row(ROW_REG, 64'd0, CFG_MATCH_CASE, CHK_NONE, 0, 0);
    add_row(ROW_REG, 64'd1, CFG_WHOLE_WORDS, CHK_NONE, 0, 0);
    // word char on the left side kills the match
    add_row(ROW_TEXT, "_", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, "c", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, "a", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, "f", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, "e", '0, CHK_MODEL, 0, 0);
    add_row(ROW_EOL, 8'h00, '0, CHK_NONE, 0, 0);
    // line end closes a held match
    add_row(ROW_TEXT, "C", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, "A", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, "F", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, "E", '0, CHK_NONE, 0, 0);
    add_row(ROW_EOL, 8'h00, '0, CHK_HIT, 2, 0);
    add_row(ROW_TEXT, "c", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, "a", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, "f", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, 8'hE9, '0, CHK_MODEL, 0, 0);
    // whole_words dropped while a match is held: held one wins, new one is lost
    add_row(ROW_REG, 64'h20, CFG_PATTERN_WORD_0, CHK_NONE, 0, 0);
    add_row(ROW_REG, 64'd1, CFG_PATTERN_LENGTH, CHK_NONE, 0, 0);
    add_row(ROW_REG, 64'd0, CFG_WHOLE_WORDS, CHK_NONE, 0, 0);
    add_row(ROW_TEXT, " ", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, " ", '0, CHK_MODEL, 0, 0);
    // zero length acts as one, exact compare
    add_row(ROW_REG, 64'h51, CFG_PATTERN_WORD_0, CHK_NONE, 0, 0);
    add_row(ROW_REG, 64'd0, CFG_PATTERN_LENGTH, CHK_NONE, 0, 0);
    add_row(ROW_REG, 64'd1, CFG_MATCH_CASE, CHK_NONE, 0, 0);
    add_row(ROW_TEXT, "q", '0, CHK_MODEL, 0, 0);
    add_row(ROW_TEXT, "Q", '0, CHK_MODEL, 0, 0);

    prev_reg = 1'b0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        if (!prev_reg) settle();
        write_reg(script[i].idx, script[i].data);
        prev_reg = 1'b1;
      end else begin
        send_request(script[i].data[7:0], script[i].kind == ROW_EOL, script[i].chk,
                     {script[i].line, script[i].col});
        prev_reg = 1'b0;
      end
    end
    settings_applied += 3;

    // random segments, idle mix rotates every segment
    for (int seg = 0; seg < 8; seg++) begin
      foreach (pbytes[k]) pbytes[k] = pick_text_byte();
      if (seg == 4) foreach (pbytes[k]) pbytes[k] = 8'hFF;
      if (seg == 5) foreach (pbytes[k]) pbytes[k] = 8'h00;
      case (seg)
        0: len = 6'd1;
        1: len = 6'd32;
        2: len = 6'd0;
        3: len = 6'd63;
        default: len = 6'($urandom_range(2, 6));
      endcase
      if (seg < 4) begin
        mc = seg[0];
        ww = seg[1];
      end else begin
        mc = $urandom_range(1);
        ww = $urandom_range(1);
      end
      load_settings(pbytes, len, mc, ww);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      start_count = requests_sent;
      while (requests_sent - start_count < 250) send_burst();
    end

    // back-pressure: every byte matches while the receiver holds off
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (pbytes[k]) pbytes[k] = 8'h00;
    pbytes[0] = "a";
    load_settings(pbytes, 6'd1, 1'b0, 1'b0);
    hold_asks++;
    repeat (120) send_text(pick_variant("a"));
    settle();
    repeat (40) send_text(pick_text_byte());

    settle();
    repeat (8) @(posedge clk);
    if (expected_matches.size() != 0) begin
      $error("%0d matches never arrived", expected_matches.size());
      errors++;
    end
    $display("covered %0d requests under %0d register settings, %0d match reports checked",
             requests_sent, settings_applied, matches_seen);
    $display("included held whole-word matches, fold classes, idle mixes and a long stall");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
